// ----- hdl/fba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

    // fixed field widths
    localparam int CFG_W  = 11;
    localparam int FUNC_W = 2;
    localparam int IDX_W  = 10;
    localparam int OUT_W  = 10;

    // default sizing
    localparam int DEF_MAX_FRAMES = 1024;
    localparam int DEF_WORD_BITS  = 32;

    // frame count after reset
    localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 11'd1024;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_FREE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MARK = 2'd2;

    // request word
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  frame_index;
    } t_req;

    // result word
    typedef struct packed {
        logic             status;
        logic [OUT_W-1:0] frame_out;
        logic             redundant_op;
    } t_rsp;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NAMED_RD,
        ST_NAMED_WR,
        ST_SCAN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic named_rd;
        logic named_wr;
        logic scan_step;
        logic rsp_err;
        logic rsp_found;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic named_ok;
        logic scan_found;
        logic scan_fail;
    } t_sts;

endpackage

`default_nettype wire

// ----- hdl/fba_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fba_ctrl
    import fba_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire t_sts              i_sts,
    output t_cmd                   o_cmd,
    output logic                   busy
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    if (i_func inside {FUNC_FREE, FUNC_MARK}) begin
                        if (i_sts.named_ok) n_state = ST_NAMED_RD;
                    end else if (i_func == FUNC_FIND) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_NAMED_RD: n_state = ST_NAMED_WR;
            ST_NAMED_WR: n_state = ST_IDLE;
            ST_SCAN: begin
                if (i_sts.scan_found || i_sts.scan_fail) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                o_cmd.load = start;
                // unused code or named frame out of range fails at once
                o_cmd.rsp_err = start && ((i_func == FUNC_FIND) ? 1'b0 :
                    !((i_func inside {FUNC_FREE, FUNC_MARK}) && i_sts.named_ok));
            end
            ST_NAMED_RD: o_cmd.named_rd = 1'b1;
            ST_NAMED_WR: o_cmd.named_wr = 1'b1;
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.rsp_found = i_sts.scan_found;
                o_cmd.rsp_err   = i_sts.scan_fail;
            end
            default: o_cmd = '0;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// ----- hdl/fba_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fba_datapath
    import fba_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int WORD_BITS  = DEF_WORD_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_req             i_req,
    input  wire t_cmd             i_cmd,
    output t_sts                  o_sts,
    input  wire logic             i_cfg_valid,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    output logic                  o_done,
    output t_rsp                  o_rsp
);

    localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int SPAN_W    = $clog2((NUM_WORDS + 2) * WORD_BITS);
    localparam int CMP_W     = ((SPAN_W > CFG_W) ? SPAN_W : CFG_W) + 1;
    // exact reciprocal for frame_index / WORD_BITS over the index range
    localparam int DIV_SH    = IDX_W + $clog2(WORD_BITS);
    localparam int RECIP     = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_W   = IDX_W + 1;
    localparam int PROD_W    = IDX_W + RECIP_W;

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;

    logic [CFG_W-1:0]  r_frame_count;
    logic [AW-1:0]     r_clr_addr;
    logic [FUNC_W-1:0] r_func;
    logic [IDX_W-1:0]  r_idx;
    logic [PROD_W-1:0] r_prod;
    logic [AW-1:0]     r_q;
    logic [BW-1:0]     r_bit;
    logic [AW-1:0]     r_scan_addr;
    logic [CMP_W-1:0]  r_scan_base;
    logic [AW-1:0]     r_chk_addr;
    logic [CMP_W-1:0]  r_chk_base;
    logic              r_chk_valid;
    logic              r_done;
    t_rsp              r_rsp;

    logic [CMP_W-1:0]     cnt_ext;
    logic [CMP_W-1:0]     n_active;
    logic [PROD_W-1:0]    q_full;
    logic [PROD_W-1:0]    rem;
    logic [BW-1:0]        first_zero;
    logic                 any_zero;
    logic [CMP_W-1:0]     cand;
    logic [CMP_W-1:0]     next_base;
    logic                 cand_ok;
    logic [WORD_BITS-1:0] named_mask;
    logic                 want;
    logic                 old_bit;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [WORD_BITS-1:0] mem_wd;
    logic                 mem_re;
    logic [AW-1:0]        mem_ra;

    // active frame count, capped at capacity
    always_comb begin
        cnt_ext  = CMP_W'(r_frame_count);
        n_active = (cnt_ext > CMP_W'(MAX_FRAMES)) ? CMP_W'(MAX_FRAMES) : cnt_ext;
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_frame_count <= i_cfg_data;
        end
    end

    // word address and bit offset of the named frame
    always_comb begin
        q_full = r_prod >> DIV_SH;
        rem    = PROD_W'(r_idx) - PROD_W'(q_full * WORD_BITS);
    end

    // lowest zero bit of the word under check
    always_comb begin
        first_zero = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!r_rd_data[i]) first_zero = BW'(i);
        end
        any_zero  = ~&r_rd_data;
        cand      = r_chk_base + CMP_W'(first_zero);
        next_base = r_chk_base + CMP_W'(WORD_BITS);
        cand_ok   = cand < n_active;
    end

    // named frame update
    always_comb begin
        named_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_bit;
        want       = (r_func == FUNC_MARK);
        old_bit    = r_rd_data[r_bit];
    end

    // status to controller
    always_comb begin
        o_sts.clr_last   = (r_clr_addr == AW'(NUM_WORDS - 1));
        o_sts.named_ok   = CMP_W'(i_req.frame_index) < n_active;
        o_sts.scan_found = r_chk_valid && any_zero && cand_ok;
        o_sts.scan_fail  = r_chk_valid &&
            ((any_zero && !cand_ok) || (!any_zero && (next_base >= n_active)));
    end

    // memory port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr_addr;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = r_scan_addr;
        if (i_cmd.clr_step) begin
            mem_we = 1'b1;
        end else if (i_cmd.named_wr) begin
            mem_we = 1'b1;
            mem_wa = r_q;
            mem_wd = want ? (r_rd_data | named_mask) : (r_rd_data & ~named_mask);
        end else if (i_cmd.rsp_found) begin
            mem_we = 1'b1;
            mem_wa = r_chk_addr;
            mem_wd = r_rd_data | ({{(WORD_BITS-1){1'b0}}, 1'b1} << first_zero);
        end
        if (i_cmd.named_rd) begin
            mem_re = 1'b1;
            mem_ra = AW'(q_full);
        end else if (i_cmd.scan_step) begin
            mem_re = (CMP_W'(r_scan_addr) < CMP_W'(NUM_WORDS));
        end
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_rd_data <= r_mem[mem_ra];
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // request capture and named frame address
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_req.func;
            r_idx  <= i_req.frame_index;
            r_prod <= PROD_W'(i_req.frame_index) * PROD_W'(RECIP);
        end
        if (i_cmd.named_rd) begin
            r_q   <= AW'(q_full);
            r_bit <= BW'(rem);
        end
    end

    // scan pipeline: read one word ahead of the check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_chk_valid <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_chk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_scan_addr <= '0;
            r_scan_base <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_addr <= r_scan_addr + AW'(1);
            r_scan_base <= r_scan_base + CMP_W'(WORD_BITS);
            r_chk_addr  <= r_scan_addr;
            r_chk_base  <= r_scan_base;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.rsp_err || i_cmd.named_wr || i_cmd.rsp_found;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.rsp_err) begin
            r_rsp <= '{status: 1'b1, frame_out: '0, redundant_op: 1'b0};
        end else if (i_cmd.named_wr) begin
            r_rsp <= '{status: 1'b0, frame_out: '0, redundant_op: (old_bit == want)};
        end else if (i_cmd.rsp_found) begin
            r_rsp <= '{status: 1'b0, frame_out: OUT_W'(cand), redundant_op: 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

// ----- hdl/frame_bitmap_allocator_top.sv -----
// free or mark: result after the named read and named write states; bad frame or
//   unused code: error result registered straight from the idle state
// find: result after a one-word-per-cycle scan over the single memory read port
// a new request is taken in the cycle its predecessor's result shows
// the receiver cannot stall; each result shows for one cycle on o_done
// synchronous reset; then a clearing pass of one word per cycle (32 at defaults)
`timescale 1ns / 1ps
`default_nettype none

module frame_bitmap_allocator_top
    import fba_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int WORD_BITS  = DEF_WORD_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire t_req             i_req,
    output logic                  busy,
    output logic                  o_done,
    output t_rsp                  o_rsp,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    fba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_req.func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // bitmap, scan and result datapath
    fba_datapath #(
        .MAX_FRAMES (MAX_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ----- hdl/fba_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fba_checker
    import fba_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire t_req i_req,
    input wire logic busy,
    input wire logic o_done,
    input wire t_rsp o_rsp
);

    // clearing pass holds off requests right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> busy)
        else $error("not busy after reset release");

    // a result only shows while the block is idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while busy");

    // an accepted request either keeps the block busy or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted request dropped");

    // unused code answers next cycle with an error
    a_unused_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.func != FUNC_FREE && i_req.func != FUNC_FIND &&
         i_req.func != FUNC_MARK) |=> (o_done && o_rsp.status && !o_rsp.redundant_op))
        else $error("unused code not rejected");

endmodule

bind frame_bitmap_allocator_top fba_checker u_fba_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_req   (i_req),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

`default_nettype wire

// ----- bench/frame_bitmap_allocator_top_tb.sv -----
`timescale 1ns / 1ps

module frame_bitmap_allocator_top_tb;
    import fba_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int FRAMES       = DEF_MAX_FRAMES;
    localparam int SETTLE_CYCLES = 40;
    localparam int LIMIT_NS     = 400_000;

    // expected frame usage and the results still owed by the block
    class frame_ledger;
        bit [FRAMES-1:0]  in_use;
        logic [CFG_W-1:0] frame_count;
        t_rsp             owed[$];
        int               errors;
        int               checked;
        int               allocated;
        int               refused;
        int               redundant;

        function new();
            in_use      = '0;
            frame_count = FRAME_COUNT_RESET;
            errors      = 0;
            checked     = 0;
            allocated   = 0;
            refused     = 0;
            redundant   = 0;
        endfunction

        // apply one accepted request word and queue its result
        function void note_request(t_req req);
            t_rsp r;
            int   lim;
            r        = '0;
            r.status = 1'b1;
            lim      = (frame_count > FRAMES) ? FRAMES : int'(frame_count);
            case (req.func)
                FUNC_FREE, FUNC_MARK: begin
                    if (req.frame_index < lim) begin
                        r.status       = 1'b0;
                        r.redundant_op = (in_use[req.frame_index] == (req.func == FUNC_MARK));
                        in_use[req.frame_index] = (req.func == FUNC_MARK);
                    end
                end
                FUNC_FIND: begin
                    // lowest free frame below the count
                    for (int i = 0; i < lim && r.status; i++) begin
                        if (!in_use[i]) begin
                            in_use[i]   = 1'b1;
                            r.status    = 1'b0;
                            r.frame_out = OUT_W'(i);
                        end
                    end
                    if (!r.status)
                        allocated++;
                end
                default: ;
            endcase
            if (r.status)
                refused++;
            if (r.redundant_op)
                redundant++;
            owed.push_back(r);
        endfunction

        // compare one result word with the oldest expectation
        function void check_result(t_rsp got);
            t_rsp want;
            if (owed.size() == 0) begin
                $error("result word with nothing outstanding: %h", got);
                errors++;
                return;
            end
            want = owed.pop_front();
            checked++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.frame_out !== want.frame_out) begin
                $error("frame_out: expected %0d, got %0d", want.frame_out, got.frame_out);
                errors++;
            end
            if (got.redundant_op !== want.redundant_op) begin
                $error("redundant_op: expected %0d, got %0d",
                       want.redundant_op, got.redundant_op);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    t_req             i_req;
    logic             busy;
    logic             o_done;
    t_rsp             o_rsp;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    frame_ledger ledger = new();
    int          n_sent = 0;
    int          n_cfg  = 0;

    frame_bitmap_allocator_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watch both sides at the rising edge; a result shown now belongs to an older word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                ledger.check_result(o_rsp);
            if (start && !busy) begin
                ledger.note_request(i_req);
                n_sent++;
            end
        end
    end

    // present one request word and hold it until taken; start stays high on return
    task automatic issue(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] x);
        t_req r;
        r.func        = f;
        r.frame_index = x;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // sender gap with junk on the request bus
    task automatic pause(input int cycles);
        start <= 1'b0;
        i_req <= {FUNC_W'($urandom), IDX_W'($urandom)};
        repeat (cycles) @(negedge i_clk);
    endtask

    // stop sending and wait for every owed result
    task automatic drain();
        start <= 1'b0;
        while (ledger.owed.size() != 0)
            @(negedge i_clk);
    endtask

    // frame count write over the config channel
    task automatic write_count(input logic [CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        ledger.frame_count = v;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one frame count, then random traffic mostly near the valid range
    task automatic run_phase(input logic [CFG_W-1:0] count, input int items, input bit idle_on);
        int               lim;
        int               pick;
        logic [FUNC_W-1:0] f;
        logic [IDX_W-1:0]  x;
        drain();
        write_count(count);
        lim = (count > FRAMES) ? FRAMES : int'(count);
        repeat (items) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                f = FUNC_FIND;
            else if (pick < 70)
                f = FUNC_FREE;
            else if (pick < 95)
                f = FUNC_MARK;
            else
                f = FUNC_UNUSED;
            if ($urandom_range(0, 9) < 7)
                x = IDX_W'($urandom_range(0, (lim + 3 > FRAMES - 1) ? FRAMES - 1 : lim + 3));
            else
                x = IDX_W'($urandom);
            issue(f, x);
            if (idle_on && $urandom_range(0, 3) == 0)
                pause($urandom_range(1, 15));
        end
    endtask

    initial begin
        logic [CFG_W-1:0] count;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // count above capacity behaves as full capacity
        write_count(11'd2047);
        issue(FUNC_FIND, 10'd1023);
        issue(FUNC_FIND, 10'd0);
        issue(FUNC_MARK, 10'd1023);
        issue(FUNC_MARK, 10'd1023);
        issue(FUNC_FREE, 10'd1023);
        issue(FUNC_FREE, 10'd1023);
        issue(FUNC_FREE, 10'd0);
        issue(FUNC_FIND, 10'd512);
        issue(FUNC_UNUSED, 10'd1023);
        issue(FUNC_UNUSED, 10'd0);
        issue(FUNC_MARK, 10'd2);
        issue(FUNC_FIND, 10'd0);

        // zero count: nothing is valid
        drain();
        write_count(11'd0);
        issue(FUNC_FREE, 10'd0);
        issue(FUNC_MARK, 10'd0);
        issue(FUNC_FIND, 10'd0);

        // single frame, already taken, then exhausted
        drain();
        write_count(11'd1);
        issue(FUNC_FIND, 10'd0);
        issue(FUNC_FREE, 10'd0);
        issue(FUNC_FIND, 10'd0);
        issue(FUNC_FIND, 10'd0);
        issue(FUNC_MARK, 10'd1);
        issue(FUNC_FREE, 10'd1023);

        // random phases across counts, extremes included
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: count = 11'd1024;
                1: count = 11'd2047;
                2: count = 11'd33;
                3: count = 11'd1;
                4: count = 11'd0;
                5: count = CFG_W'($urandom_range(2, 200));
                6: count = CFG_W'($urandom_range(1, 2047));
                default: count = 11'd32;
            endcase
            run_phase(count, 55, 1'b1);
        end

        // back-to-back traffic to finish
        run_phase(11'd64, 50, 1'b0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d request words, %0d results checked, %0d frame count writes",
                 n_sent, ledger.checked, n_cfg);
        $display("finds that allocated %0d, refused requests %0d, redundant free or mark %0d",
                 ledger.allocated, ledger.refused, ledger.redundant);
        if (ledger.errors == 0)
            $display("frame_bitmap_allocator_top_tb: clean");
        else
            $display("frame_bitmap_allocator_top_tb: errors");
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #(LIMIT_NS);
        $display("run timed out");
        $display("frame_bitmap_allocator_top_tb: errors");
        $finish;
    end

endmodule
